[rtl/core/itaf_pkg.sv]
// Shared types, character codes and helpers for the integer to ASCII formatter.
package itaf_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_WIDTH_DEF  = 63;
   localparam int WIDTH_W        = 6;
   localparam int CHAR_W         = 8;
   localparam int DIGIT_W        = 4;

   localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [DIGIT_W-1:0] DEC_MAX_DIGIT = 4'd9;
   localparam logic [CHAR_W-1:0]  DEC_BASE      = 8'd10;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

   typedef struct packed {
      logic               neg;
      logic [WIDTH_W-1:0] width;
   } emit_job_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] c;
      if (d > DEC_MAX_DIGIT) begin
         c = CH_LOWER_A + {4'd0, d} - DEC_BASE;
      end else begin
         c = CH_ZERO + {4'd0, d};
      end
      return c;
   endfunction

endpackage

[rtl/core/itaf_conv.sv]
// Bit-serial binary to BCD converter (shift-add-3), or nibble pass-through for hex, with leading-zero digit scan.
module itaf_conv
   import itaf_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int DIG_N      = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        is_hex,
   input  logic [VALUE_BITS-1:0]       mag,
   output unit_status_type             status,
   output logic [DIGIT_W*DIG_N-1:0]    digits,
   output logic [$clog2(DIG_N+1)-1:0]  ndig
);

   localparam int DIG_W = DIGIT_W * DIG_N;
   localparam int ND_W  = $clog2(DIG_N + 1);
   localparam int CNT_W = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  scan_ff, scan_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [DIG_W-1:0]      dig_ff, dig_in, dig_adj;
   logic [ND_W-1:0]       nd_ff, nd_in;
   logic                  top_zero, shrink, done;

   // each BCD digit of 5 or more gets 3 added before the shift
   always_comb begin
      for (int i = 0; i < DIG_N; i++) begin
         if (dig_ff[DIGIT_W*i +: DIGIT_W] >= 4'd5) begin
            dig_adj[DIGIT_W*i +: DIGIT_W] = dig_ff[DIGIT_W*i +: DIGIT_W] + 4'd3;
         end else begin
            dig_adj[DIGIT_W*i +: DIGIT_W] = dig_ff[DIGIT_W*i +: DIGIT_W];
         end
      end
   end

   assign top_zero = (dig_ff[DIG_W-1 -: DIGIT_W] == '0);
   assign shrink   = top_zero && (nd_ff != ND_W'(1));
   assign done     = busy_ff && scan_ff && !shrink;

   always_comb begin
      busy_in = busy_ff;
      scan_in = scan_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      dig_in  = dig_ff;
      nd_in   = nd_ff;
      if (start) begin
         busy_in = 1'b1;
         nd_in   = ND_W'(DIG_N);
         mag_in  = mag;
         cnt_in  = CNT_W'(VALUE_BITS);
         if (is_hex) begin
            // hex digits are the nibbles themselves
            scan_in = 1'b1;
            dig_in  = DIG_W'(mag);
         end else begin
            scan_in = 1'b0;
            dig_in  = '0;
         end
      end else if (busy_ff && !scan_ff) begin
         dig_in = {dig_adj[DIG_W-2:0], mag_ff[VALUE_BITS-1]};
         mag_in = {mag_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            scan_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (shrink) begin
            dig_in = {dig_ff[DIG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            nd_in  = nd_ff - ND_W'(1);
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         scan_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         scan_ff <= scan_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      mag_ff <= mag_in;
      dig_ff <= dig_in;
      nd_ff  <= nd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done;
   assign digits      = dig_ff;
   assign ndig        = nd_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("conversion started while busy");

   a_nd_nonzero: assert property (@(posedge clock) disable iff (reset)
      busy_ff && scan_ff |-> nd_ff != '0)
      else $error("digit count reached zero");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy_ff)
      else $error("converter still busy after done");

endmodule

[rtl/core/itaf_emit.sv]
// Character sequencer: sign, space padding, digits, into a registered output stage.
module itaf_emit
   import itaf_pkg::*;
#(
   parameter int DIG_N = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  emit_job_type                job,
   input  logic [DIGIT_W*DIG_N-1:0]    digits,
   input  logic [$clog2(DIG_N+1)-1:0]  ndig,
   output unit_status_type             status,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [CHAR_W-1:0]           rsp_tdata,   // [7:0] out_char
   output logic                        rsp_tlast
);

   localparam int DIG_W = DIGIT_W * DIG_N;
   localparam int ND_W  = $clog2(DIG_N + 1);

   logic               busy_ff, busy_in;
   logic               sign_ff, sign_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;
   logic [DIG_W-1:0]   dig_ff, dig_in;
   logic [ND_W-1:0]    nd_ff, nd_in;
   logic [WIDTH_W-1:0] pad_ff, pad_in;
   logic [WIDTH_W-1:0] nd_wide;
   logic               slot_free, done;

   assign slot_free = !valid_ff || rsp_tready;
   assign nd_wide   = WIDTH_W'(ndig);
   assign done      = busy_ff && slot_free && !sign_ff && (pad_ff == '0)
                      && (nd_ff == ND_W'(1));

   always_comb begin
      busy_in  = busy_ff;
      sign_in  = sign_ff;
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      dig_in   = dig_ff;
      nd_in    = nd_ff;
      pad_in   = pad_ff;
      if (valid_ff && rsp_tready) begin
         valid_in = 1'b0;
      end
      if (start) begin
         busy_in = 1'b1;
         sign_in = job.neg;
         dig_in  = digits;
         nd_in   = ndig;
         pad_in  = (job.width > nd_wide) ? job.width - nd_wide : '0;
      end else if (busy_ff && slot_free) begin
         valid_in = 1'b1;
         if (sign_ff) begin
            char_in = CH_MINUS;
            last_in = 1'b0;
            sign_in = 1'b0;
         end else if (pad_ff != '0) begin
            char_in = CH_SPACE;
            last_in = 1'b0;
            pad_in  = pad_ff - WIDTH_W'(1);
         end else begin
            char_in = digit_char(dig_ff[DIG_W-1 -: DIGIT_W]);
            dig_in  = {dig_ff[DIG_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            nd_in   = nd_ff - ND_W'(1);
            last_in = (nd_ff == ND_W'(1));
            if (nd_ff == ND_W'(1)) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         sign_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         sign_ff  <= sign_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      dig_ff  <= dig_in;
      nd_ff   <= nd_in;
      pad_ff  <= pad_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done;
   assign rsp_tvalid  = valid_ff;
   assign rsp_tdata   = char_ff;
   assign rsp_tlast   = last_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("emit started while busy");

   a_nd_live: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> nd_ff != '0)
      else $error("emitter busy with no digits left");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      done |=> valid_ff && last_ff && !busy_ff)
      else $error("final digit not flagged as last");

endmodule

[rtl/core/int_to_ascii_formatter.sv]
// Top level of the integer to ASCII formatter: input transfer, sign handling, sequencing.
//
// Each number goes through a bit-serial shift-add-3 conversion over its VALUE_BITS
// bits in decimal (none in hex), then a scan that drops leading zero digits (leaving
// up to DIG_N digits, 10 for 32-bit values), then the characters on the result
// channel, which carries one character per transfer. The next number is taken once
// the last character has entered the output register. The value field is VALUE_BITS wide.
module int_to_ascii_formatter
   import itaf_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // value [VALUE_BITS-1:0], width [VALUE_BITS+5:VALUE_BITS], zero fill above
   input  logic [((VALUE_BITS+WIDTH_W+7)/8)*8-1:0] req_tdata,
   input  logic [1:0]                            req_tuser,   // [0] is_signed, [1] is_hex
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [CHAR_W-1:0]                     rsp_tdata,   // [7:0] out_char
   output logic                                  rsp_tlast
);

   localparam int DIG_N = ((VALUE_BITS * 1233) >> 12) + 1;
   localparam int DIG_W = DIGIT_W * DIG_N;
   localparam int ND_W  = $clog2(DIG_N + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]            state_ff, state_in;
   emit_job_type          job_ff, job_in;
   logic                  accept;
   logic [VALUE_BITS-1:0] value, mag;
   logic [WIDTH_W-1:0]    width, width_cl;
   logic                  neg;
   unit_status_type       conv_st, emit_st;
   logic [DIG_W-1:0]      digits;
   logic [ND_W-1:0]       ndig;

   assign value      = req_tdata[VALUE_BITS-1:0];
   assign width      = req_tdata[VALUE_BITS +: WIDTH_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   assign neg      = req_tuser[0] && value[VALUE_BITS-1];
   assign mag      = neg ? ~value + VALUE_BITS'(1) : value;
   assign width_cl = (width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : width;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_CONV;
               job_in.neg   = neg;
               // the minus sign takes one place of the field
               job_in.width = (neg && width_cl != '0) ? width_cl - WIDTH_W'(1) : width_cl;
            end
         end
         ST_CONV: begin
            if (conv_st.done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (emit_st.done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   itaf_conv #(
      .VALUE_BITS (VALUE_BITS),
      .DIG_N      (DIG_N)
   ) u_conv (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .is_hex (req_tuser[1]),
      .mag    (mag),
      .status (conv_st),
      .digits (digits),
      .ndig   (ndig)
   );

   itaf_emit #(
      .DIG_N (DIG_N)
   ) u_emit (
      .clock      (clock),
      .reset      (reset),
      .start      (conv_st.done),
      .job        (job_ff),
      .digits     (digits),
      .ndig       (ndig),
      .status     (emit_st),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> !conv_st.busy && !emit_st.busy)
      else $error("transfer taken while a number is in progress");

   a_conv_phase: assert property (@(posedge clock) disable iff (reset)
      conv_st.done |-> state_ff == ST_CONV)
      else $error("conversion finished outside conversion phase");

   a_emit_phase: assert property (@(posedge clock) disable iff (reset)
      emit_st.done |-> state_ff == ST_EMIT && !conv_st.busy)
      else $error("emit finished outside emit phase");

endmodule
